### hdl/min_max_bucket_decimator_core_assert.svh
// Assertion macros for the min/max bucket decimator.
// Each macro is one concurrent assertion, clocked on the rising edge and off during reset.
`ifndef MIN_MAX_BUCKET_DECIMATOR_CORE_ASSERT_SVH
`define MIN_MAX_BUCKET_DECIMATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMBD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mmbd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MMBD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mmbd assertion failed");

`endif

### hdl/mmbd_pkg.sv
// Shared types and constants of the min/max bucket decimator.
// No dependencies; every other file but the assertion macro header imports this package.
`default_nettype none

package mmbd_pkg;

  localparam int unsigned KEY_W      = 32;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned COUNT_W    = 24;
  localparam int unsigned BUCKET_W   = 16;
  localparam int unsigned PROD_W     = 41;
  localparam int unsigned SUM_W      = 56;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned DIV_STEPS  = SUM_W;
  localparam int unsigned DIV_CNT_W  = 6;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic {
    CFG_TOTAL_COUNT = 1'b0,
    CFG_NUM_BUCKETS = 1'b1
  } cfg_reg_e;

  // Back part sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_EMIT_MIN,
    BK_EMIT_MAX
  } back_state_e;

  // Configuration as seen by the front part.
  typedef struct packed {
    logic [COUNT_W-1:0]  total_count;
    logic [BUCKET_W-1:0] num_buckets;
  } cfg_t;

  // Summary of one closed bucket, passed from front to back.
  typedef struct packed {
    logic [SUM_W-1:0]          key_sum;
    logic [COUNT_W-1:0]        valid_count;
    logic signed [VALUE_W-1:0] min_value;
    logic signed [VALUE_W-1:0] max_value;
    logic                      end_of_frame;
    logic [BUCKET_W-1:0]       bucket_number;
  } bucket_rec_t;

  // Queue status flags.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

`default_nettype wire

### hdl/mmbd_if.sv
// Stream interfaces of the min/max bucket decimator: samples in, points out.
// Depends on mmbd_pkg for the field widths.
`default_nettype none

interface mmbd_sample_if import mmbd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [KEY_W-1:0]          sample_key;
  logic signed [VALUE_W-1:0] sample_value;
  logic                      sample_valid;

  modport source (output valid, sample_key, sample_value, sample_valid, input ready);
  modport sink   (input valid, sample_key, sample_value, sample_valid, output ready);
endinterface

interface mmbd_point_if import mmbd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [KEY_W-1:0]          point_key;
  logic signed [VALUE_W-1:0] point_value;
  logic                      gap;
  logic                      last_of_pair;
  logic                      end_of_frame;
  logic [BUCKET_W-1:0]       bucket_number;

  modport source (output valid, point_key, point_value, gap, last_of_pair, end_of_frame,
                  bucket_number, input ready);
  modport sink   (input valid, point_key, point_value, gap, last_of_pair, end_of_frame,
                  bucket_number, output ready);
endinterface

`default_nettype wire

### hdl/mmbd_front.sv
// Front part: takes one sample a cycle while the queue has room, tracks bucket boundaries
// and statistics, and pushes a summary record when a bucket closes. Depends on mmbd_pkg, mmbd_if.
`default_nettype none

module mmbd_front import mmbd_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire cfg_t         cfg_i,
  mmbd_sample_if.sink       sample_i,
  input  wire fifo_status_t fifo_stat_i,
  output logic              push_o,
  output bucket_rec_t       rec_o
);

  logic [COUNT_W-1:0]        pos_q, pos_d;
  logic [PROD_W-1:0]         prod_q, prod_d;
  logic [PROD_W-1:0]         thr_q, thr_d;
  logic [BUCKET_W-1:0]       bc_q, bc_d;
  logic signed [VALUE_W-1:0] min_q, min_d;
  logic signed [VALUE_W-1:0] max_q, max_d;
  logic [SUM_W-1:0]          sum_q, sum_d;
  logic [COUNT_W-1:0]        cnt_q, cnt_d;

  logic [COUNT_W-1:0]        t_eff, nb_raw, nb_eff;
  logic [PROD_W-1:0]         thr_cur, prod_cur, prod_next;
  logic [BUCKET_W-1:0]       bc_cur;
  logic [PROD_W:0]           lhs;
  logic signed [VALUE_W-1:0] min_new, max_new;
  logic [SUM_W-1:0]          sum_new;
  logic [COUNT_W-1:0]        cnt_new;
  logic                      accept, frame_end, close;

  // Clamp the configuration: zero acts as one, buckets never exceed samples.
  always_comb begin
    t_eff  = (cfg_i.total_count == '0) ? COUNT_W'(1) : cfg_i.total_count;
    nb_raw = (cfg_i.num_buckets == '0) ? COUNT_W'(1) : COUNT_W'(cfg_i.num_buckets);
    nb_eff = (nb_raw > t_eff) ? t_eff : nb_raw;
  end

  assign sample_i.ready = !fifo_stat_i.full;
  assign accept         = sample_i.valid && !fifo_stat_i.full;

  // Boundary values in force for this sample; position zero restarts the frame.
  always_comb begin
    if (pos_q == '0) begin
      thr_cur  = PROD_W'(t_eff);
      prod_cur = '0;
      bc_cur   = '0;
    end else begin
      thr_cur  = thr_q;
      prod_cur = prod_q;
      bc_cur   = bc_q;
    end
  end

  // Running statistics including this sample.
  always_comb begin
    min_new = min_q;
    max_new = max_q;
    sum_new = sum_q;
    cnt_new = cnt_q;
    if (sample_i.sample_valid) begin
      if (sample_i.sample_value < min_q) min_new = sample_i.sample_value;
      if (sample_i.sample_value > max_q) max_new = sample_i.sample_value;
      sum_new = sum_q + SUM_W'(sample_i.sample_key);
      cnt_new = cnt_q + COUNT_W'(1);
    end
  end

  // Bucket close decision: frame end, or the product has passed the threshold.
  always_comb begin
    frame_end = ({1'b0, pos_q} + (COUNT_W+1)'(1)) >= {1'b0, t_eff};
    lhs       = {1'b0, prod_cur} + (PROD_W+1)'({nb_eff, 1'b0});
    close     = frame_end || (lhs > {1'b0, thr_cur});
    prod_next = prod_cur + PROD_W'(nb_eff);
  end

  // Next state of the counters and accumulators.
  always_comb begin
    pos_d  = pos_q;
    prod_d = prod_q;
    thr_d  = thr_q;
    bc_d   = bc_q;
    min_d  = min_q;
    max_d  = max_q;
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (!close) begin
        pos_d  = pos_q + COUNT_W'(1);
        prod_d = prod_next;
        thr_d  = thr_cur;
        bc_d   = bc_cur;
        min_d  = min_new;
        max_d  = max_new;
        sum_d  = sum_new;
        cnt_d  = cnt_new;
      end else begin
        min_d = VALUE_MAX;
        max_d = VALUE_MIN;
        sum_d = '0;
        cnt_d = '0;
        if (frame_end) begin
          pos_d  = '0;
          prod_d = '0;
          thr_d  = '0;
          bc_d   = '0;
        end else begin
          pos_d  = pos_q + COUNT_W'(1);
          prod_d = prod_next;
          thr_d  = thr_cur + PROD_W'(t_eff);
          bc_d   = bc_cur + BUCKET_W'(1);
        end
      end
    end
  end

  // Record of the closing bucket.
  always_comb begin
    push_o              = accept && close;
    rec_o.key_sum       = sum_new;
    rec_o.valid_count   = cnt_new;
    rec_o.min_value     = min_new;
    rec_o.max_value     = max_new;
    rec_o.end_of_frame  = frame_end;
    rec_o.bucket_number = bc_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      prod_q <= '0;
      thr_q  <= '0;
      bc_q   <= '0;
      min_q  <= VALUE_MAX;
      max_q  <= VALUE_MIN;
      sum_q  <= '0;
      cnt_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      prod_q <= prod_d;
      thr_q  <= thr_d;
      bc_q   <= bc_d;
      min_q  <= min_d;
      max_q  <= max_d;
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### hdl/mmbd_fifo.sv
// Short queue of closed-bucket records between the front and back parts.
// Depends on mmbd_pkg.
`default_nettype none

module mmbd_fifo import mmbd_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire bucket_rec_t  rec_i,
  input  wire logic         pop_i,
  output bucket_rec_t       rec_o,
  output fifo_status_t      stat_o
);

  bucket_rec_t          mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]     fill_q;
  logic                 do_push, do_pop;

  assign stat_o.full  = (fill_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat_o.empty = (fill_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rec_o        = mem_q[rd_ptr_q];

  // Storage, written at the tail.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      if (do_push && !do_pop) begin
        fill_q <= fill_q + (FIFO_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - (FIFO_AW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hdl/mmbd_back.sv
// Back part: takes bucket records, divides key sum by valid count one bit a cycle
// and emits the minimum and maximum points. Depends on mmbd_pkg, mmbd_if.
`default_nettype none

module mmbd_back import mmbd_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire bucket_rec_t  rec_i,
  input  wire fifo_status_t fifo_stat_i,
  output logic              pop_o,
  mmbd_point_if.source      point_o
);

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  back_state_e         state_q, state_d;
  bucket_rec_t         rec_q;
  logic [COUNT_W:0]    rem_q, rem_shift;
  logic [SUM_W-1:0]    quo_q;
  logic [DIV_CNT_W-1:0] step_q;
  logic                rem_ge, out_free, load_min, load_max, is_gap;

  logic                      out_valid_q;
  logic [KEY_W-1:0]          out_key_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic                      out_gap_q, out_last_q, out_eof_q;
  logic [BUCKET_W-1:0]       out_bucket_q;

  assign out_free = !out_valid_q || point_o.ready;
  assign is_gap   = (rec_q.valid_count == '0);

  // One restoring division step.
  always_comb begin
    rem_shift = {rem_q[COUNT_W-1:0], quo_q[SUM_W-1]};
    rem_ge    = rem_shift >= {1'b0, rec_q.valid_count};
  end

  // Sequencer: fetch, divide unless the bucket is all gap, then the two points of the pair.
  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_min = 1'b0;
    load_max = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!fifo_stat_i.empty) begin
          pop_o   = 1'b1;
          state_d = (rec_i.valid_count == '0) ? BK_EMIT_MIN : BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        if (step_q == DIV_LAST) state_d = BK_EMIT_MIN;
      end
      BK_EMIT_MIN: begin
        if (out_free) begin
          load_min = 1'b1;
          state_d  = BK_EMIT_MAX;
        end
      end
      BK_EMIT_MAX: begin
        if (out_free) begin
          load_max = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        step_q <= '0;
      end else if (state_q == BK_DIVIDE) begin
        step_q <= step_q + DIV_CNT_W'(1);
      end
      if (load_min || load_max) begin
        out_valid_q <= 1'b1;
      end else if (point_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Record, divider datapath and output register.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= rec_i;
      rem_q <= '0;
      quo_q <= rec_i.key_sum;
    end else if (state_q == BK_DIVIDE) begin
      rem_q <= rem_ge ? (rem_shift - {1'b0, rec_q.valid_count}) : rem_shift;
      quo_q <= {quo_q[SUM_W-2:0], rem_ge};
    end
    if (load_min || load_max) begin
      out_key_q    <= is_gap ? '0 : quo_q[KEY_W-1:0];
      out_value_q  <= is_gap ? '0 : (load_min ? rec_q.min_value : rec_q.max_value);
      out_gap_q    <= is_gap;
      out_last_q   <= load_max;
      out_eof_q    <= rec_q.end_of_frame;
      out_bucket_q <= rec_q.bucket_number;
    end
  end

  assign point_o.valid         = out_valid_q;
  assign point_o.point_key     = out_key_q;
  assign point_o.point_value   = out_value_q;
  assign point_o.gap           = out_gap_q;
  assign point_o.last_of_pair  = out_last_q;
  assign point_o.end_of_frame  = out_eof_q;
  assign point_o.bucket_number = out_bucket_q;

endmodule

`default_nettype wire

### hdl/min_max_bucket_decimator_core.sv
// Top level of the min/max bucket decimator: configuration registers, front, queue, back.
// Depends on mmbd_pkg, mmbd_if, mmbd_front, mmbd_fifo and mmbd_back.
`default_nettype none

// The front part takes one sample every clock cycle while the four-entry bucket queue
// has room. A bucket with at least one valid sample takes the back part through a fetch,
// 56 steps of the bit-serial key-sum divider and the emission of its two points; an
// all-gap bucket skips the divider. Output stalls lengthen this. When buckets close faster
// than the back part drains them, the divider sets the pace and sample ready drops while
// the queue is full.

module min_max_bucket_decimator_core import mmbd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire cfg_reg_e              cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  mmbd_sample_if.sink                sample_i,
  mmbd_point_if.source               point_o
);

  cfg_t         cfg_q;
  bucket_rec_t  push_rec, pop_rec;
  fifo_status_t fifo_stat;
  logic         push, pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_count <= COUNT_W'(1);
      cfg_q.num_buckets <= BUCKET_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TOTAL_COUNT: cfg_q.total_count <= cfg_data_i[COUNT_W-1:0];
        CFG_NUM_BUCKETS: cfg_q.num_buckets <= cfg_data_i[BUCKET_W-1:0];
        default: ;
      endcase
    end
  end

  mmbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .sample_i    (sample_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  mmbd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (push_rec),
    .pop_i  (pop),
    .rec_o  (pop_rec),
    .stat_o (fifo_stat)
  );

  mmbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (pop_rec),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .point_o     (point_o)
  );

endmodule

`default_nettype wire

### hdl/mmbd_checker.sv
// Port-level checks for the min/max bucket decimator, bound to the top level.
// Depends on mmbd_pkg and the assertion macro header.
`default_nettype none

`include "min_max_bucket_decimator_core_assert.svh"

module mmbd_checker import mmbd_pkg::*; (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic [KEY_W-1:0]          point_key_i,
  input wire logic signed [VALUE_W-1:0] point_value_i,
  input wire logic                      gap_i,
  input wire logic                      last_of_pair_i,
  input wire logic                      end_of_frame_i,
  input wire logic [BUCKET_W-1:0]       bucket_number_i
);

  // A stalled point keeps its payload.
  `MMBD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(point_key_i) && $stable(point_value_i) && $stable(bucket_number_i))

  // Gap points carry zero key and value.
  `MMBD_ASSERT_IMP(a_gap_zero, clk_i, rst_ni, out_valid_i && gap_i, point_key_i == '0 && point_value_i == '0)

  // The maximum point of the same bucket follows a taken minimum point at once.
  `MMBD_ASSERT_NXT(a_pair_order, clk_i, rst_ni, out_valid_i && out_ready_i && !last_of_pair_i, out_valid_i && last_of_pair_i && bucket_number_i == $past(bucket_number_i) && end_of_frame_i == $past(end_of_frame_i) && gap_i == $past(gap_i))

endmodule

bind min_max_bucket_decimator_core mmbd_checker u_mmbd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (point_o.valid),
  .out_ready_i     (point_o.ready),
  .point_key_i     (point_o.point_key),
  .point_value_i   (point_o.point_value),
  .gap_i           (point_o.gap),
  .last_of_pair_i  (point_o.last_of_pair),
  .end_of_frame_i  (point_o.end_of_frame),
  .bucket_number_i (point_o.bucket_number)
);

`default_nettype wire

### bench/mmbd_point_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the min/max bucket decimator: follows register writes and sample beats,
// predicts the point beats and compares them in order. Depends on mmbd_pkg and mmbd_if.

module mmbd_point_checker import mmbd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  cfg_reg_e              cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mmbd_sample_if                sample_mon,
  mmbd_point_if                 point_mon,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;
    logic                      gap;
    logic                      last_of_pair;
    logic                      end_of_frame;
    logic [BUCKET_W-1:0]       bucket;
  } point_t;

  // Points still owed by the block, oldest first.
  point_t expected_points[$];
  point_t want;

  // Register copies.
  logic [COUNT_W-1:0]        cfg_total;
  logic [BUCKET_W-1:0]       cfg_buckets;

  // Frame and bucket progress.
  logic [COUNT_W-1:0]        frame_pos;
  logic [PROD_W-1:0]         pos_product;
  logic [PROD_W-1:0]         next_boundary;
  logic [BUCKET_W-1:0]       bucket_idx;
  logic signed [VALUE_W-1:0] lo_value;
  logic signed [VALUE_W-1:0] hi_value;
  logic [SUM_W-1:0]          key_total;
  logic [COUNT_W-1:0]        hit_count;

  function automatic void clear_bucket();
    lo_value  = VALUE_MAX;
    hi_value  = VALUE_MIN;
    key_total = '0;
    hit_count = '0;
  endfunction

  // Fold one sample into the running bucket and queue the pair when the bucket closes.
  task automatic predict_sample(input logic [KEY_W-1:0] key,
                                input logic signed [VALUE_W-1:0] value, input logic ok);
    logic [COUNT_W-1:0] frame_len;
    logic [COUNT_W-1:0] buckets;
    logic               at_end;
    logic               closing;
    point_t             pt;
    frame_len = (cfg_total == '0) ? COUNT_W'(1) : cfg_total;
    buckets   = (cfg_buckets == '0) ? COUNT_W'(1) : COUNT_W'(cfg_buckets);
    if (buckets > frame_len) begin
      buckets = frame_len;
    end
    // A new frame reloads the first boundary and restarts the bucket count.
    if (frame_pos == '0) begin
      next_boundary = PROD_W'(frame_len);
      pos_product   = '0;
      bucket_idx    = '0;
    end
    if (ok) begin
      if (value < lo_value) begin
        lo_value = value;
      end
      if (value > hi_value) begin
        hi_value = value;
      end
      key_total = key_total + SUM_W'(key);
      hit_count = hit_count + 1'b1;
    end
    at_end  = (64'(frame_pos) + 64'd1) >= 64'(frame_len);
    closing = at_end || (64'(pos_product) + 64'(buckets) * 2 > 64'(next_boundary));
    if (closing) begin
      for (int k = 0; k < 2; k++) begin
        if (hit_count == '0) begin
          pt.key   = '0;
          pt.value = '0;
          pt.gap   = 1'b1;
        end else begin
          pt.key   = KEY_W'(key_total / SUM_W'(hit_count));
          pt.value = (k == 0) ? lo_value : hi_value;
          pt.gap   = 1'b0;
        end
        pt.last_of_pair = (k == 1);
        pt.end_of_frame = at_end;
        pt.bucket       = bucket_idx;
        expected_points.push_back(pt);
      end
      clear_bucket();
    end
    // Advance the running products; the frame end puts everything back to zero.
    if (closing && at_end) begin
      frame_pos     = '0;
      pos_product   = '0;
      next_boundary = '0;
      bucket_idx    = '0;
    end else begin
      frame_pos   = frame_pos + 1'b1;
      pos_product = pos_product + PROD_W'(buckets);
      if (closing) begin
        next_boundary = next_boundary + PROD_W'(frame_len);
        bucket_idx    = bucket_idx + 1'b1;
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [63:0] exp_val,
                                      input logic [63:0] got_val);
    if (got_val !== exp_val) begin
      fail_count_o++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_val, got_val);
    end
  endfunction

  // Sample beats feed the prediction, point beats are checked, then register writes land.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_total     = COUNT_W'(1);
      cfg_buckets   = BUCKET_W'(1);
      frame_pos     = '0;
      pos_product   = '0;
      next_boundary = '0;
      bucket_idx    = '0;
      clear_bucket();
      expected_points.delete();
      pending_o = 0;
    end else begin
      if (sample_mon.valid && sample_mon.ready) begin
        predict_sample(sample_mon.sample_key, sample_mon.sample_value, sample_mon.sample_valid);
      end
      if (point_mon.valid && point_mon.ready) begin
        if (expected_points.size() == 0) begin
          fail_count_o++;
          $display("%0t: point beat with nothing expected: expected none, got key %0h value %0h",
                   $time, point_mon.point_key, point_mon.point_value);
        end else begin
          want = expected_points.pop_front();
          check_field("point_key", want.key, point_mon.point_key);
          check_field("point_value", want.value, point_mon.point_value);
          check_field("gap", want.gap, point_mon.gap);
          check_field("last_of_pair", want.last_of_pair, point_mon.last_of_pair);
          check_field("end_of_frame", want.end_of_frame, point_mon.end_of_frame);
          check_field("bucket_number", want.bucket, point_mon.bucket_number);
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TOTAL_COUNT: begin
            cfg_total = cfg_data_i[COUNT_W-1:0];
          end
          CFG_NUM_BUCKETS: begin
            cfg_buckets = cfg_data_i[BUCKET_W-1:0];
          end
          default: begin
          end
        endcase
      end
      pending_o = expected_points.size();
    end
  end

endmodule

### bench/min_max_bucket_decimator_core_test.sv
`timescale 1ns / 1ps
// Top of the min/max bucket decimator bench: clock, reset, sample stimulus, output stalls
// and verdict. Depends on mmbd_pkg, mmbd_if, the block and mmbd_point_checker.

module min_max_bucket_decimator_core_test;
  import mmbd_pkg::*;

  localparam int unsigned ITEM_TARGET   = 1950;
  localparam int unsigned HOLD_CYCLES   = 1200;
  localparam int unsigned QUIET_LIMIT   = 20000;
  localparam int unsigned SETTLE_CYCLES = 80;

  typedef enum int unsigned {RX_FLOW, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;
  typedef enum int unsigned {KEY_SCATTER, KEY_RAMP, KEY_TOP} key_style_e;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_reg_e              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  logic                  long_hold_req = 1'b0;
  int unsigned           quiet_cycles = 0;

  // Sender pacing and content style of the current phase.
  int unsigned           burst_left = 0;
  int unsigned           sent_items = 0;
  bit                    steady_flow;
  int unsigned           valid_pct;
  key_style_e            key_style;
  logic [KEY_W-1:0]      key_base;
  logic [KEY_W-1:0]      key_step;
  bit                    narrow_values;

  mmbd_sample_if sample_bus ();
  mmbd_point_if  point_bus ();

  min_max_bucket_decimator_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .sample_i    (sample_bus),
    .point_o     (point_bus)
  );

  mmbd_point_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .sample_mon   (sample_bus),
    .point_mon    (point_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5ns clk = ~clk;

  // Watchdog: too long without a beat on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (sample_bus.valid && sample_bus.ready) || (point_bus.valid && point_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Point receiver: random stall patterns, plus one long hold when asked for.
  initial begin
    rx_mode_e    mode;
    int unsigned span;
    point_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold_req) begin
        @(negedge clk);
        point_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        long_hold_req = 1'b0;
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      for (int unsigned tick = 0; tick < span; tick++) begin
        if (long_hold_req) begin
          break;
        end
        @(negedge clk);
        case (mode)
          RX_FLOW:   point_bus.ready <= 1'b1;
          RX_COIN:   point_bus.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: point_bus.ready <= ($urandom_range(0, 3) == 0);
          default:   point_bus.ready <= (tick % 6 != 5);
        endcase
      end
    end
  end

  // Offer one sample beat and wait for it to be taken; bursts are separated by random gaps unless the flow is steady.
  task automatic push_sample(input logic [KEY_W-1:0] key, input logic signed [VALUE_W-1:0] value,
                             input logic ok);
    int unsigned pause;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      pause = steady_flow ? 0 : $urandom_range(0, 9);
      if (pause != 0) begin
        @(negedge clk);
        sample_bus.valid <= 1'b0;
        repeat (pause - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    sample_bus.valid        <= 1'b1;
    sample_bus.sample_key   <= key;
    sample_bus.sample_value <= value;
    sample_bus.sample_valid <= ok;
    do @(posedge clk); while (!sample_bus.ready);
    sent_items++;
  endtask

  task automatic write_reg(input cfg_reg_e index, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Stop sending, wait for every owed point, then give the back part time to go quiet.
  task automatic settle();
    @(negedge clk);
    sample_bus.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Reprogram both registers once the block is idle; the upper bucket-count data bits are junk.
  task automatic set_frame(input int unsigned total, input int unsigned buckets);
    settle();
    write_reg(CFG_TOTAL_COUNT, CFG_DATA_W'(total));
    write_reg(CFG_NUM_BUCKETS, {8'($urandom_range(0, 255)), 16'(buckets)});
  endtask

  // Stream samples in the style of the current phase.
  task automatic run_samples(input int unsigned count);
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;
    for (int unsigned i = 0; i < count; i++) begin
      case (key_style)
        KEY_RAMP: key = key_base + KEY_W'(i) * key_step;
        KEY_TOP:  key = 32'hFFFF_FFFF - KEY_W'($urandom_range(0, 255));
        default:  key = $urandom();
      endcase
      if ($urandom_range(0, 7) == 0) begin
        value = ($urandom_range(0, 1) != 0) ? VALUE_MAX : VALUE_MIN;
      end else if (narrow_values) begin
        value = VALUE_W'($urandom_range(0, 200)) - 16'sd100;
      end else begin
        value = VALUE_W'($urandom());
      end
      push_sample(key, value, $urandom_range(1, 100) <= valid_pct);
    end
  endtask

  task automatic pick_style();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    valid_pct     = (roll < 6) ? 100 : (roll < 8) ? 90 : (roll < 9) ? 50 : 0;
    steady_flow   = ($urandom_range(0, 3) == 0);
    key_style     = key_style_e'($urandom_range(0, 2));
    key_base      = $urandom();
    key_step      = $urandom_range(0, 1000);
    narrow_values = ($urandom_range(0, 1) != 0);
  endtask

  initial begin
    int unsigned phase;
    int unsigned sel;
    int unsigned total;
    int unsigned buckets;
    int unsigned frame_len;
    int unsigned count;
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_index               = CFG_TOTAL_COUNT;
    cfg_data                = '0;
    sample_bus.valid        = 1'b0;
    sample_bus.sample_key   = '0;
    sample_bus.sample_value = '0;
    sample_bus.sample_valid = 1'b0;
    steady_flow             = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: every sample is a frame of its own; extremes and a lone gap bucket.
    push_sample(32'h0000_0000, VALUE_MIN, 1'b1);
    push_sample(32'hFFFF_FFFF, VALUE_MAX, 1'b1);
    push_sample(32'h1234_5678, 16'sd0, 1'b0);

    // Two buckets of five: the key mean needs more than 32 bits of sum, then a gap bucket.
    set_frame(5, 2);
    push_sample(32'hFFFF_FFFF, VALUE_MAX, 1'b1);
    push_sample(32'hFFFF_FFFE, VALUE_MIN, 1'b1);
    push_sample(32'h0000_0007, 16'sd5, 1'b0);
    push_sample(32'h0000_0008, -16'sd1, 1'b0);
    push_sample(32'h0000_0009, 16'sd0, 1'b0);

    // Both registers zero behave as one.
    set_frame(0, 0);
    push_sample(32'h8000_0000, -16'sd2, 1'b1);
    push_sample(32'h7FFF_FFFF, 16'sd1, 1'b0);

    // More buckets than samples are clamped to one sample per bucket.
    set_frame(3, 10);
    push_sample(32'h0000_0100, 16'sd100, 1'b1);
    push_sample(32'h0000_0200, -16'sd100, 1'b0);
    push_sample(32'h5555_AAAA, 16'sd3, 1'b1);

    // Frame cut short by a register change part-way through.
    set_frame(6, 3);
    push_sample(32'h0000_0010, 16'sd10, 1'b1);
    push_sample(32'h0000_0020, 16'sd20, 1'b1);
    push_sample(32'h0000_0030, -16'sd30, 1'b1);
    set_frame(4, 1);
    push_sample(32'h0000_0040, 16'sd40, 1'b0);
    push_sample(32'hAAAA_5555, 16'sd7, 1'b1);

    // Random phases until the item budget is spent.
    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      pick_style();
      if (phase == 4) begin
        // One-sample buckets with the receiver held off: the queue fills and input stalls.
        set_frame(64, 64);
        valid_pct     = 90;
        steady_flow   = 1'b1;
        long_hold_req = 1'b1;
        run_samples(80);
      end else if (phase == 9) begin
        // Largest settings; only the odd bucket closes within the phase.
        set_frame(24'hFF_FFFF, 16'hFFFF);
        key_style = KEY_RAMP;
        run_samples(300);
      end else begin
        sel = $urandom_range(0, 9);
        if (sel <= 5) begin
          total   = $urandom_range(1, 120);
          buckets = $urandom_range(1, total);
        end else if (sel == 6) begin
          total   = $urandom_range(1, 40);
          buckets = total + $urandom_range(1, 30);
        end else if (sel == 7) begin
          total   = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(2, 60);
          buckets = (total == 0) ? $urandom_range(0, 5) : 0;
        end else if (sel == 8) begin
          total   = $urandom_range(200, 3000);
          buckets = $urandom_range(1, 60);
        end else begin
          buckets = $urandom_range(30000, 65535);
          total   = buckets * $urandom_range(1, 3) + $urandom_range(0, buckets - 1);
        end
        set_frame(total, buckets);
        frame_len = (total == 0) ? 1 : total;
        // Mostly whole frames with random content, now and then a broken-off frame.
        if (frame_len <= 300 && $urandom_range(0, 3) != 0) begin
          count = frame_len * $urandom_range(1, (240 / frame_len > 1) ? 240 / frame_len : 1);
        end else begin
          count = $urandom_range(20, 160);
        end
        run_samples(count);
      end
      phase++;
    end

    settle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/mmbd_pkg.sv
hdl/mmbd_if.sv
hdl/mmbd_front.sv
hdl/mmbd_fifo.sv
hdl/mmbd_back.sv
hdl/min_max_bucket_decimator_core.sv
hdl/mmbd_checker.sv
bench/mmbd_point_checker.sv
bench/min_max_bucket_decimator_core_test.sv
